// ===== src/svt_pkg.sv =====
// Package: shared types and constants for the sphere vertex tessellator.
`timescale 1ns / 1ps
`default_nettype none
package svt_pkg;
    localparam int IDX_W = 5;
    localparam int CNT_W = 5;
    localparam int CFG_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLICES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STACKS = 2'd2;
    localparam logic [15:0] QUARTER = 16'd16384;

    typedef struct packed {
        logic [IDX_W-1:0] slice_index;
        logic [IDX_W-1:0] stack_index;
        logic strip_restart;
    } svt_in_t;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
        logic [15:0] tex_s;
        logic [15:0] tex_t;
        logic last_of_quad;
    } svt_out_t;

    // one evaluated vertex plus restart mark, front to back
    typedef struct packed {
        logic restart;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
        logic [15:0] tex_s;
        logic [15:0] tex_t;
    } svt_vtx_t;

    localparam logic signed [31:0] SIN_C0 = 32'sd1686629713;
    localparam logic signed [31:0] SIN_C1 = -32'sd693598668;
    localparam logic signed [31:0] SIN_C2 = 32'sd85569305;
    localparam logic signed [31:0] SIN_C3 = -32'sd5026995;
    localparam logic signed [31:0] SIN_C4 = 32'sd172272;
endpackage
`default_nettype wire

// ===== src/svt_if.sv =====
// Valid/ready channel interface.
`timescale 1ns / 1ps
`default_nettype none
interface svt_if #(parameter type payload_t = logic) ();
    logic valid;
    logic ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/svt_divider.sv =====
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module svt_divider
    import svt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [20:0] dividend,
    input  wire logic [CNT_W-1:0] divisor,
    output logic             done,
    output logic [20:0]      quotient
);
    logic [20:0] q_reg;
    logic [CNT_W:0] rem_reg;
    logic [4:0] cnt_reg;
    logic busy_reg;
    logic [CNT_W+1:0] trial;

    assign trial = {rem_reg, q_reg[20]};
    assign quotient = q_reg;
    assign done = busy_reg && (cnt_reg == 5'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg <= 5'd21;
        end
        else if (busy_reg && cnt_reg != 5'd0)
            cnt_reg <= cnt_reg - 5'd1;
        else
            busy_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg && cnt_reg != 5'd0)
        begin
            if (trial >= {2'b00, divisor})
            begin
                rem_reg <= (CNT_W+1)'(trial - {2'b00, divisor});
                q_reg <= {q_reg[19:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[CNT_W:0];
                q_reg <= {q_reg[19:0], 1'b0};
            end
        end
    end
endmodule
`default_nettype wire

// ===== src/svt_front.sv =====
// Front end: phase division, sine/cosine, normal and position evaluation.
`timescale 1ns / 1ps
`default_nettype none
module svt_front
    import svt_pkg::*;
#(
    parameter int MAX_DIVISIONS = 31
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [15:0] radius,
    input  wire logic [CNT_W-1:0] slice_count,
    input  wire logic [CNT_W-1:0] stack_count,
    svt_if.sink              in_ch,
    output logic             vtx_valid,
    output svt_vtx_t         vtx,
    input  wire logic        vtx_ready
);
    typedef enum logic [3:0] {
        S_IDLE, S_DIV_PS, S_DIV_PT, S_DIV_TS, S_DIV_TT,
        S_SIN, S_POLY, S_QUAD, S_NORM, S_POS, S_OUT
    } state_t;

    state_t state_reg;
    svt_in_t in_reg;
    logic [CNT_W-1:0] n_reg, m_reg, i_reg, j_reg;
    logic [15:0] pa_reg, pb_reg, ts_reg, tt_reg;
    logic [1:0] sel_reg;      // which of four quarter sines
    logic [2:0] step_reg;
    logic signed [31:0] acc_reg;
    logic [30:0] u_reg, u2_reg;
    logic signed [15:0] qs_reg [4];
    logic signed [15:0] sa_reg, ca_reg, sb_reg, cb_reg;
    logic signed [15:0] nx_reg, ny_reg, nz_reg;
    logic signed [15:0] px_reg, py_reg, pz_reg;
    logic [1:0] pc_reg;
    logic vtx_valid_reg;

    function automatic logic [CNT_W-1:0] eff(input logic [CNT_W-1:0] c);
        if (c == '0) return CNT_W'(1);
        if (32'(c) > MAX_DIVISIONS) return CNT_W'(MAX_DIVISIONS);
        return c;
    endfunction

    function automatic logic signed [15:0] rnd14(input logic signed [47:0] v);
        logic [47:0] a;
        logic [47:0] r;
        a = v[47] ? 48'(-v) : 48'(v);
        r = (a + 48'd8192) >> 14;
        return v[47] ? -$signed(r[15:0]) : $signed(r[15:0]);
    endfunction

    function automatic logic signed [15:0] rndsat(input logic signed [47:0] v);
        logic [47:0] a;
        logic [47:0] r;
        logic signed [48:0] s;
        a = v[47] ? 48'(-v) : 48'(v);
        r = (a + 48'd8192) >> 14;
        s = v[47] ? -$signed({1'b0, r}) : $signed({1'b0, r});
        if (s > 49'sd32767) return 16'sh7fff;
        if (s < -49'sd32768) return 16'sh8000;
        return s[15:0];
    endfunction

    // signed a times non-negative b, shifted by 30 toward zero
    function automatic logic signed [63:0] mq30(input logic signed [31:0] a,
                                                input logic [30:0] b);
        logic [31:0] mag;
        logic [62:0] m;
        mag = a[31] ? 32'(-a) : 32'(a);
        m = 63'(mag * b) >> 30;
        return a[31] ? -$signed({1'b0, m}) : $signed({1'b0, m});
    endfunction

    function automatic logic signed [31:0] coef(input logic [2:0] k);
        case (k)
            3'd0: return SIN_C0;
            3'd1: return SIN_C1;
            3'd2: return SIN_C2;
            3'd3: return SIN_C3;
            default: return SIN_C4;
        endcase
    endfunction

    // divider
    logic div_start, div_done;
    logic [20:0] div_dividend, div_q;
    logic [CNT_W-1:0] div_divisor;

    svt_divider u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dividend),
        .divisor(div_divisor), .done(div_done), .quotient(div_q)
    );

    logic [15:0] rarg;
    logic [15:0] phase_sel;
    always_comb
    begin
        phase_sel = sel_reg[1] ? pb_reg : pa_reg;
        rarg = {2'b00, phase_sel[13:0]};
        if (sel_reg[0]) rarg = QUARTER - rarg;
    end

    assign in_ch.ready = (state_reg == S_IDLE);
    assign vtx_valid = vtx_valid_reg;

    always_comb
    begin
        div_start = 1'b0;
        div_dividend = '0;
        div_divisor = n_reg;
        unique case (state_reg)
            S_DIV_PS: div_divisor = n_reg;
            S_DIV_PT: div_divisor = m_reg;
            S_DIV_TS: div_divisor = n_reg;
            S_DIV_TT: div_divisor = m_reg;
            default: div_divisor = n_reg;
        endcase
        if (state_reg == S_IDLE && in_ch.valid)
        begin
            div_start = 1'b1;
            div_divisor = eff(slice_count);
            div_dividend = 21'(({16'd0, (in_ch.data.slice_index > eff(slice_count)
                ? eff(slice_count) : in_ch.data.slice_index)} << 16)
                + 21'(eff(slice_count) >> 1));
        end
        else if (div_done)
        begin
            unique case (state_reg)
                S_DIV_PS:
                begin
                    div_start = 1'b1;
                    div_divisor = m_reg;
                    div_dividend = 21'(({16'd0, j_reg} << 15) + 21'(m_reg >> 1));
                end
                S_DIV_PT:
                begin
                    div_start = 1'b1;
                    div_divisor = n_reg;
                    div_dividend = 21'(({16'd0, i_reg} << 15) + 21'(n_reg >> 1));
                end
                S_DIV_TS:
                begin
                    div_start = 1'b1;
                    div_divisor = m_reg;
                    div_dividend = 21'(({16'd0, j_reg} << 15) + 21'(m_reg >> 1));
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        logic signed [63:0] qv;
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            vtx_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                    if (in_ch.valid)
                    begin
                        in_reg <= in_ch.data;
                        n_reg <= eff(slice_count);
                        m_reg <= eff(stack_count);
                        i_reg <= in_ch.data.slice_index > eff(slice_count)
                            ? eff(slice_count) : in_ch.data.slice_index;
                        j_reg <= in_ch.data.stack_index > eff(stack_count)
                            ? eff(stack_count) : in_ch.data.stack_index;
                        state_reg <= S_DIV_PS;
                    end
                S_DIV_PS: if (div_done) begin pa_reg <= div_q[15:0]; state_reg <= S_DIV_PT; end
                S_DIV_PT: if (div_done) begin pb_reg <= div_q[15:0]; state_reg <= S_DIV_TS; end
                S_DIV_TS: if (div_done) begin ts_reg <= div_q[15:0]; state_reg <= S_DIV_TT; end
                S_DIV_TT:
                    if (div_done)
                    begin
                        tt_reg <= div_q[15:0];
                        sel_reg <= 2'd0;
                        state_reg <= S_SIN;
                    end
                S_SIN:
                begin
                    u_reg <= 31'(rarg) << 16;
                    u2_reg <= 31'((32'(rarg) * 32'(rarg)) << 2);
                    acc_reg <= SIN_C4;
                    step_reg <= 3'd3;
                    state_reg <= S_POLY;
                end
                S_POLY:
                begin
                    // one Horner step a cycle, then the final multiply by u
                    if (step_reg == 3'd7)
                    begin
                        qv = mq30(acc_reg, u_reg);
                        if (qv < 0) qv = 0;
                        qv = (qv + 64'sd32768) >>> 16;
                        if (qv > 64'sd16384) qv = 64'sd16384;
                        qs_reg[sel_reg] <= qv[15:0];
                        sel_reg <= sel_reg + 2'd1;
                        state_reg <= (sel_reg == 2'd3) ? S_QUAD : S_SIN;
                    end
                    else
                    begin
                        acc_reg <= coef(step_reg) + 32'(mq30(acc_reg, u2_reg));
                        step_reg <= step_reg - 3'd1;
                    end
                end
                S_QUAD:
                begin
                    unique case (pa_reg[15:14])
                        2'd0: begin sa_reg <= qs_reg[0]; ca_reg <= qs_reg[1]; end
                        2'd1: begin sa_reg <= qs_reg[1]; ca_reg <= -qs_reg[0]; end
                        2'd2: begin sa_reg <= -qs_reg[0]; ca_reg <= -qs_reg[1]; end
                        default: begin sa_reg <= -qs_reg[1]; ca_reg <= qs_reg[0]; end
                    endcase
                    unique case (pb_reg[15:14])
                        2'd0: begin sb_reg <= qs_reg[2]; cb_reg <= qs_reg[3]; end
                        2'd1: begin sb_reg <= qs_reg[3]; cb_reg <= -qs_reg[2]; end
                        2'd2: begin sb_reg <= -qs_reg[2]; cb_reg <= -qs_reg[3]; end
                        default: begin sb_reg <= -qs_reg[3]; cb_reg <= qs_reg[2]; end
                    endcase
                    state_reg <= S_NORM;
                end
                S_NORM:
                begin
                    nx_reg <= rnd14(48'(sa_reg * sb_reg));
                    ny_reg <= rnd14(48'(ca_reg * sb_reg));
                    nz_reg <= cb_reg;
                    pc_reg <= 2'd0;
                    state_reg <= S_POS;
                end
                S_POS:
                begin
                    // one radius multiply a cycle
                    unique case (pc_reg)
                        2'd0: px_reg <= rndsat(48'(nx_reg * $signed({1'b0, radius})));
                        2'd1: py_reg <= rndsat(48'(ny_reg * $signed({1'b0, radius})));
                        default: pz_reg <= rndsat(48'(nz_reg * $signed({1'b0, radius})));
                    endcase
                    pc_reg <= pc_reg + 2'd1;
                    if (pc_reg == 2'd2)
                    begin
                        vtx_valid_reg <= 1'b1;
                        state_reg <= S_OUT;
                    end
                end
                default:
                    if (vtx_ready)
                    begin
                        vtx_valid_reg <= 1'b0;
                        state_reg <= S_IDLE;
                    end
            endcase
        end
    end

    always_comb
    begin
        vtx.restart = in_reg.strip_restart;
        vtx.pos_x = px_reg;
        vtx.pos_y = py_reg;
        vtx.pos_z = pz_reg;
        vtx.norm_x = nx_reg;
        vtx.norm_y = ny_reg;
        vtx.norm_z = nz_reg;
        vtx.tex_s = ts_reg;
        vtx.tex_t = tt_reg;
    end
endmodule
`default_nettype wire

// ===== src/svt_back.sv =====
// Back end: vertex queue, quad buffer and triangle emission.
`timescale 1ns / 1ps
`default_nettype none
module svt_back
    import svt_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic vtx_valid,
    input  svt_vtx_t  vtx,
    output logic      vtx_ready,
    svt_if.source     out_ch
);
    // two-entry queue between front and back
    svt_vtx_t q_mem [2];
    logic q_wp_reg, q_rp_reg;
    logic [1:0] q_cnt_reg;
    svt_vtx_t quad_reg [4];
    logic [2:0] fill_reg;
    logic emit_reg;
    logic [2:0] k_reg;
    logic [1:0] e_sel;
    logic q_pop, q_push;

    assign vtx_ready = (q_cnt_reg != 2'd2);
    assign q_push = vtx_valid && vtx_ready;
    assign q_pop = !emit_reg && (q_cnt_reg != 2'd0);

    always_comb
    begin
        case (k_reg)
            3'd0: e_sel = 2'd0;
            3'd1: e_sel = 2'd1;
            3'd2: e_sel = 2'd2;
            3'd3: e_sel = 2'd0;
            3'd4: e_sel = 2'd2;
            default: e_sel = 2'd3;
        endcase
        out_ch.data.pos_x = quad_reg[e_sel].pos_x;
        out_ch.data.pos_y = quad_reg[e_sel].pos_y;
        out_ch.data.pos_z = quad_reg[e_sel].pos_z;
        out_ch.data.norm_x = quad_reg[e_sel].norm_x;
        out_ch.data.norm_y = quad_reg[e_sel].norm_y;
        out_ch.data.norm_z = quad_reg[e_sel].norm_z;
        out_ch.data.tex_s = quad_reg[e_sel].tex_s;
        out_ch.data.tex_t = quad_reg[e_sel].tex_t;
        out_ch.data.last_of_quad = (k_reg == 3'd5);
    end
    assign out_ch.valid = emit_reg;

    always_ff @(posedge clk)
    begin
        if (q_push) q_mem[q_wp_reg] <= vtx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wp_reg <= 1'b0;
            q_rp_reg <= 1'b0;
            q_cnt_reg <= '0;
            fill_reg <= '0;
            emit_reg <= 1'b0;
            k_reg <= '0;
        end
        else
        begin
            if (q_push) q_wp_reg <= ~q_wp_reg;
            if (q_pop) q_rp_reg <= ~q_rp_reg;
            q_cnt_reg <= q_cnt_reg + 2'(q_push) - 2'(q_pop);
            if (q_pop)
            begin
                if (q_mem[q_rp_reg].restart)
                begin
                    quad_reg[0] <= q_mem[q_rp_reg];
                    fill_reg <= 3'd1;
                end
                else
                begin
                    quad_reg[fill_reg[1:0]] <= q_mem[q_rp_reg];
                    fill_reg <= fill_reg + 3'd1;
                    if (fill_reg == 3'd3)
                    begin
                        emit_reg <= 1'b1;
                        k_reg <= '0;
                    end
                end
            end
            else if (emit_reg && out_ch.ready)
            begin
                k_reg <= k_reg + 3'd1;
                if (k_reg == 3'd5)
                begin
                    emit_reg <= 1'b0;
                    quad_reg[0] <= quad_reg[2];
                    quad_reg[1] <= quad_reg[3];
                    fill_reg <= 3'd2;
                end
            end
        end
    end
endmodule
`default_nettype wire

// ===== src/sphere_vertex_tessellator.sv =====
// Top level of the sphere vertex tessellator.
// Input channel in_ch carries one grid point (slice, stack, restart mark).
// Output channel out_ch carries vertices; a full quad gives six transfers,
// the sixth marked last_of_quad. Nothing leaves until four vertices are held.
// Per input the front end runs four divisions on one shared restoring
// divider, four quarter-sine evaluations, the normal products and three
// radius multiplies; it takes no new input until its vertex is passed on.
// A two-entry queue lets the front evaluate the next vertex while the back
// emits; the back drains six vertices at one per cycle when out_ch is ready.
// A stalled receiver holds the current vertex; the queue then fills and the
// front stops accepting. Reset clears control state and sets radius 256 and
// both counts to 16; the quad buffer is empty after reset.
// Config writes (cfg_we, cfg_index, cfg_data) must only be issued while no
// item is in flight.
`timescale 1ns / 1ps
`default_nettype none
module sphere_vertex_tessellator
    import svt_pkg::*;
#(
    parameter int MAX_DIVISIONS = 31
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data,
    svt_if.sink       in_ch,
    svt_if.source     out_ch
);
    logic [15:0] radius_reg;
    logic [CNT_W-1:0] slices_reg, stacks_reg;
    logic vtx_valid, vtx_ready;
    svt_vtx_t vtx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= 16'd256;
            slices_reg <= CNT_W'(16);
            stacks_reg <= CNT_W'(16);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RADIUS: radius_reg <= cfg_data;
                REG_SLICES: slices_reg <= cfg_data[CNT_W-1:0];
                REG_STACKS: stacks_reg <= cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    svt_front #(.MAX_DIVISIONS(MAX_DIVISIONS)) u_front (
        .clk(clk), .rst_n(rst_n), .radius(radius_reg), .slice_count(slices_reg),
        .stack_count(stacks_reg), .in_ch(in_ch), .vtx_valid(vtx_valid), .vtx(vtx),
        .vtx_ready(vtx_ready)
    );

    svt_back u_back (
        .clk(clk), .rst_n(rst_n), .vtx_valid(vtx_valid), .vtx(vtx),
        .vtx_ready(vtx_ready), .out_ch(out_ch)
    );
endmodule
`default_nettype wire
